### rtl/core/rme_pkg.sv
// rme_pkg: widths, modifier codes, transaction and pipeline types, core-size wrap
// used by the interfaces and every module of the mod execute unit; no dependencies
`default_nettype none

package rme_pkg;

  localparam int CORE_SIZE = 8000;
  localparam int NUM_W     = 13;
  localparam int CMD_W     = 3;
  localparam int DIV_BITS  = NUM_W;
  localparam int NUM_LANES = 2;
  localparam int LANE_A    = 0;
  localparam int LANE_B    = 1;
  // decode stage, one stage per quotient bit, output register
  localparam int PIPE_DEPTH = DIV_BITS + 2;

  typedef enum logic [CMD_W-1:0] {
    MOD_A     = 3'd0,
    MOD_B     = 3'd1,
    MOD_AB    = 3'd2,
    MOD_BA    = 3'd3,
    MOD_X     = 3'd4,
    MOD_F     = 3'd5,
    MOD_I     = 3'd6,
    MOD_UNDEF = 3'd7
  } rme_mod_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [NUM_W-1:0] pc;
    logic [NUM_W-1:0] a_offset;
    logic [NUM_W-1:0] b_offset;
    logic [NUM_W-1:0] src_a_number;
    logic [NUM_W-1:0] src_b_number;
    logic [NUM_W-1:0] dst_a_number;
    logic [NUM_W-1:0] dst_b_number;
  } rme_in_t;

  typedef struct packed {
    logic             status;
    logic [NUM_W-1:0] new_a_number;
    logic [NUM_W-1:0] new_b_number;
    logic             write_a;
    logic             write_b;
    logic [NUM_W-1:0] target_address;
    logic [NUM_W-1:0] source_address;
    logic [NUM_W-1:0] next_pc;
  } rme_out_t;

  // what travels beside the lanes down the pipeline
  typedef struct packed {
    logic             fail;
    logic             wr_a;
    logic             wr_b;
    logic [NUM_W-1:0] dst_a;
    logic [NUM_W-1:0] dst_b;
    logic [NUM_W-1:0] tgt_addr;
    logic [NUM_W-1:0] src_addr;
    logic [NUM_W-1:0] npc;
  } rme_side_t;

  typedef struct packed {
    logic [NUM_W-1:0] dividend;
    logic [NUM_W-1:0] divisor;
  } rme_lane_op_t;

  localparam logic [NUM_W+1:0] CoreSz  = (NUM_W+2)'(CORE_SIZE);
  localparam logic [NUM_W+1:0] CoreSz2 = (NUM_W+2)'(2 * CORE_SIZE);

  // reduce a value below three core sizes (sum of two 13-bit fields at most)
  function automatic logic [NUM_W-1:0] rme_wrap(input logic [NUM_W:0] v);
    logic [NUM_W+1:0] x;
    logic [NUM_W+1:0] r;
    x = {1'b0, v};
    if (x >= CoreSz2) begin
      r = x - CoreSz2;
    end else if (x >= CoreSz) begin
      r = x - CoreSz;
    end else begin
      r = x;
    end
    return r[NUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/rme_stream_if.sv
// rme_in_if and rme_out_if: valid/ready channels carrying one instruction or one result
// depends on rme_pkg for the payload structs
`default_nettype none

interface rme_in_if import rme_pkg::*; ();
  logic    valid;
  logic    ready;
  rme_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rme_out_if import rme_pkg::*; ();
  logic     valid;
  logic     ready;
  rme_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/rme_decode.sv
// rme_decode: operand reduction, modifier decode, fail check, addresses and next pc
// depends on rme_pkg
`default_nettype none

module rme_decode import rme_pkg::*; (
  input  rme_in_t                          data_i,
  output rme_side_t                        side_o,
  output rme_lane_op_t [NUM_LANES-1:0]     lane_op_o
);

  logic [NUM_W-1:0] sa, sb, da, db;
  logic             sa_zero, sb_zero;
  logic             fail, wr_a, wr_b;
  rme_mod_e         cmd;

  assign cmd = rme_mod_e'(data_i.command);
  assign sa  = rme_wrap({1'b0, data_i.src_a_number});
  assign sb  = rme_wrap({1'b0, data_i.src_b_number});
  assign da  = rme_wrap({1'b0, data_i.dst_a_number});
  assign db  = rme_wrap({1'b0, data_i.dst_b_number});

  assign sa_zero = (sa == '0);
  assign sb_zero = (sb == '0);

  always_comb begin
    fail = 1'b0;
    wr_a = 1'b0;
    wr_b = 1'b0;
    case (cmd)
      MOD_A: begin
        fail = sa_zero;
        wr_a = 1'b1;
      end
      MOD_B: begin
        fail = sb_zero;
        wr_b = 1'b1;
      end
      MOD_AB: begin
        fail = sa_zero;
        wr_b = 1'b1;
      end
      MOD_BA: begin
        fail = sb_zero;
        wr_a = 1'b1;
      end
      MOD_X, MOD_F, MOD_I: begin
        fail = sa_zero || sb_zero;
        wr_a = 1'b1;
        wr_b = 1'b1;
      end
      default: begin
        fail = 1'b1;
      end
    endcase
  end

  // lane a makes the new a-number, lane b the new b-number
  always_comb begin
    lane_op_o[LANE_A].dividend = da;
    lane_op_o[LANE_A].divisor  = (cmd inside {MOD_BA, MOD_X}) ? sb : sa;
    lane_op_o[LANE_B].dividend = db;
    lane_op_o[LANE_B].divisor  = (cmd inside {MOD_AB, MOD_X}) ? sa : sb;
  end

  always_comb begin
    side_o.fail     = fail;
    side_o.wr_a     = wr_a && !fail;
    side_o.wr_b     = wr_b && !fail;
    side_o.dst_a    = da;
    side_o.dst_b    = db;
    side_o.tgt_addr = rme_wrap({1'b0, data_i.pc} + {1'b0, data_i.b_offset});
    side_o.src_addr = rme_wrap({1'b0, data_i.pc} + {1'b0, data_i.a_offset});
    side_o.npc      = fail ? data_i.pc : rme_wrap({1'b0, data_i.pc} + (NUM_W+1)'(1));
  end

endmodule

`default_nettype wire

### rtl/core/rme_div_lane.sv
// rme_div_lane: pipelined restoring remainder, one dividend bit per stage
// depends on rme_pkg; stage enables come from the pipeline control in the top level
`default_nettype none

module rme_div_lane import rme_pkg::*; (
  input  logic                clk_i,
  input  logic [DIV_BITS-1:0] load_i,
  input  rme_lane_op_t        op_i,
  output logic [NUM_W-1:0]    rem_o
);

  logic [NUM_W-1:0] rem_q [DIV_BITS];
  logic [NUM_W-1:0] dvd_q [DIV_BITS];
  logic [NUM_W-1:0] dsr_q [DIV_BITS];
  logic [NUM_W-1:0] rem_d [DIV_BITS];
  logic [NUM_W-1:0] dvd_d [DIV_BITS];
  logic [NUM_W-1:0] dsr_d [DIV_BITS];
  logic [NUM_W-1:0] prev_rem [DIV_BITS];
  logic [NUM_W-1:0] prev_dvd [DIV_BITS];
  logic [NUM_W:0]   trial [DIV_BITS];
  logic [NUM_W:0]   diff [DIV_BITS];

  always_comb begin
    for (int j = 0; j < DIV_BITS; j++) begin
      if (j == 0) begin
        prev_rem[j] = '0;
        prev_dvd[j] = op_i.dividend;
        dsr_d[j]    = op_i.divisor;
      end else begin
        prev_rem[j] = rem_q[j-1];
        prev_dvd[j] = dvd_q[j-1];
        dsr_d[j]    = dsr_q[j-1];
      end
      // bring down the next dividend bit, subtract if it fits
      trial[j] = {prev_rem[j], prev_dvd[j][NUM_W-1]};
      diff[j]  = trial[j] - {1'b0, dsr_d[j]};
      if (trial[j] >= {1'b0, dsr_d[j]}) begin
        rem_d[j] = diff[j][NUM_W-1:0];
      end else begin
        rem_d[j] = trial[j][NUM_W-1:0];
      end
      dvd_d[j] = {prev_dvd[j][NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DIV_BITS; j++) begin
      if (load_i[j]) begin
        rem_q[j] <= rem_d[j];
        dvd_q[j] <= dvd_d[j];
        dsr_q[j] <= dsr_d[j];
      end
    end
  end

  assign rem_o = rem_q[DIV_BITS-1];

endmodule

`default_nettype wire

### rtl/core/redcode_mod_execute_unit.sv
// redcode_mod_execute_unit: top level of the mod instruction execute unit
// depends on rme_pkg, rme_stream_if, rme_decode and rme_div_lane
//
//   channel  dir  payload    transfer
//   in_i     in   rme_in_t   valid && ready at clk_i rise
//   out_o    out  rme_out_t  valid && ready at clk_i rise
//
// one instruction per cycle unless out_o stalls; stages: a decode register, then
// 13 stages of the bit-per-stage remainder pipeline in each of the two lanes, then
// the result register where the lanes and the side data are merged.
// rst_ni clears only the stage valid bits; the data registers are not reset.
// a stage takes new data when it is empty or the stage after it moves, so empty
// stages fill while the result waits and ready falls only once all 15 are full.
`default_nettype none

module redcode_mod_execute_unit import rme_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  rme_in_if.sink    in_i,
  rme_out_if.source out_o
);

  logic [PIPE_DEPTH-1:0] vld_q;
  logic [PIPE_DEPTH-1:0] vld_d;
  logic [PIPE_DEPTH:0]   load;

  rme_side_t                    dec_side;
  rme_lane_op_t [NUM_LANES-1:0] dec_op;
  rme_lane_op_t [NUM_LANES-1:0] op_q;
  rme_side_t                    side_q [DIV_BITS+1];
  logic [NUM_W-1:0]             lane_rem [NUM_LANES];
  rme_side_t                    side_last;
  rme_out_t                     out_d;
  rme_out_t                     out_q;

  // pipeline control
  always_comb begin
    load[PIPE_DEPTH] = out_o.ready;
    for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
      load[k] = !vld_q[k] || load[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < PIPE_DEPTH; k++) begin
      if (!load[k]) begin
        vld_d[k] = vld_q[k];
      end else if (k == 0) begin
        vld_d[k] = in_i.valid;
      end else begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_i.ready = load[0];

  rme_decode u_decode (
    .data_i    (in_i.data),
    .side_o    (dec_side),
    .lane_op_o (dec_op)
  );

  // decode register and side data shift line
  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      op_q      <= dec_op;
      side_q[0] <= dec_side;
    end
    for (int k = 1; k <= DIV_BITS; k++) begin
      if (load[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    rme_div_lane u_lane (
      .clk_i  (clk_i),
      .load_i (load[DIV_BITS:1]),
      .op_i   (op_q[l]),
      .rem_o  (lane_rem[l])
    );
  end

  // merge lanes with the side data
  assign side_last = side_q[DIV_BITS];

  always_comb begin
    out_d.status         = side_last.fail;
    out_d.write_a        = side_last.wr_a;
    out_d.write_b        = side_last.wr_b;
    out_d.target_address = side_last.tgt_addr;
    out_d.source_address = side_last.src_addr;
    out_d.next_pc        = side_last.npc;
    if (side_last.fail) begin
      out_d.new_a_number = '0;
      out_d.new_b_number = '0;
    end else begin
      out_d.new_a_number = side_last.wr_a ? lane_rem[LANE_A] : side_last.dst_a;
      out_d.new_b_number = side_last.wr_b ? lane_rem[LANE_B] : side_last.dst_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[PIPE_DEPTH-1]) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = vld_q[PIPE_DEPTH-1];
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

### sim/tb_redcode_mod_execute_unit.sv
// tb_redcode_mod_execute_unit: self-checking bench for the mod instruction execute unit
// needs rme_pkg, rme_stream_if and the redcode_mod_execute_unit rtl
// directed table, then random instructions, checked against a remainder model
`default_nettype none

module tb_redcode_mod_execute_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rme_pkg::*;

  localparam int N_RANDOM = 1050;
  localparam int MAX_REPORTED = 10;

  typedef struct packed {
    rme_in_t  stim;
    logic     typed;
    rme_out_t result;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  rme_in_if  instr_ch ();
  rme_out_if result_ch ();

  redcode_mod_execute_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (instr_ch.sink),
    .out_o  (result_ch.source)
  );

  rme_out_t mod_results_q[$];
  dir_row_t dir_tab[$];
  bit       no_idle;
  int       n_errors;
  int       n_sent;
  int       n_checked;
  int       n_failed_instr;
  int       n_writes;

  always #10 clk_i = ~clk_i;

  // remainder semantics of one mod instruction, all numbers reduced to the core first
  function automatic rme_out_t mod_execute(rme_in_t ins);
    int unsigned pc, ao, bo, sa, sb, da, db, na, nb;
    bit          bad, wa, wb;
    rme_out_t    res;
    pc = ins.pc;
    ao = ins.a_offset;
    bo = ins.b_offset;
    sa = ins.src_a_number % CORE_SIZE;
    sb = ins.src_b_number % CORE_SIZE;
    da = ins.dst_a_number % CORE_SIZE;
    db = ins.dst_b_number % CORE_SIZE;
    na = da;
    nb = db;
    wa = 1'b0;
    wb = 1'b0;
    bad = 1'b0;
    case (ins.command)
      MOD_A: begin
        if (sa == 0) bad = 1'b1;
        else begin na = da % sa; wa = 1'b1; end
      end
      MOD_B: begin
        if (sb == 0) bad = 1'b1;
        else begin nb = db % sb; wb = 1'b1; end
      end
      MOD_AB: begin
        if (sa == 0) bad = 1'b1;
        else begin nb = db % sa; wb = 1'b1; end
      end
      MOD_BA: begin
        if (sb == 0) bad = 1'b1;
        else begin na = da % sb; wa = 1'b1; end
      end
      MOD_X: begin
        if (sa == 0 || sb == 0) bad = 1'b1;
        else begin na = da % sb; nb = db % sa; wa = 1'b1; wb = 1'b1; end
      end
      MOD_F, MOD_I: begin
        if (sa == 0 || sb == 0) bad = 1'b1;
        else begin na = da % sa; nb = db % sb; wa = 1'b1; wb = 1'b1; end
      end
      default: begin
        bad = 1'b1;
      end
    endcase
    if (bad) begin
      na = 0;
      nb = 0;
      wa = 1'b0;
      wb = 1'b0;
    end
    res.status         = bad;
    res.new_a_number   = NUM_W'(na);
    res.new_b_number   = NUM_W'(nb);
    res.write_a        = wa;
    res.write_b        = wb;
    res.target_address = NUM_W'((pc + bo) % CORE_SIZE);
    res.source_address = NUM_W'((pc + ao) % CORE_SIZE);
    res.next_pc        = bad ? NUM_W'(pc) : NUM_W'((pc + 1) % CORE_SIZE);
    return res;
  endfunction

  function automatic rme_in_t instr(rme_mod_e m, int pc, int ao, int bo,
                                    int sa, int sb, int da, int db);
    rme_in_t ins;
    ins.command      = m;
    ins.pc           = NUM_W'(pc);
    ins.a_offset     = NUM_W'(ao);
    ins.b_offset     = NUM_W'(bo);
    ins.src_a_number = NUM_W'(sa);
    ins.src_b_number = NUM_W'(sb);
    ins.dst_a_number = NUM_W'(da);
    ins.dst_b_number = NUM_W'(db);
    return ins;
  endfunction

  // a failing instruction writes nothing and leaves the pc where it was
  function automatic rme_out_t fail_res(int pc, int tgt, int src);
    rme_out_t res;
    res                = '0;
    res.status         = 1'b1;
    res.target_address = NUM_W'(tgt);
    res.source_address = NUM_W'(src);
    res.next_pc        = NUM_W'(pc);
    return res;
  endfunction

  function automatic string fmt_res(rme_out_t r);
    return $sformatf("st=%0d na=%0d nb=%0d wa=%0d wb=%0d tgt=%0d src=%0d npc=%0d",
                     r.status, r.new_a_number, r.new_b_number, r.write_a, r.write_b,
                     r.target_address, r.source_address, r.next_pc);
  endfunction

  // zero, the core size itself, out-of-range codes and small divisors get extra weight
  function automatic int rand_num();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 12) return CORE_SIZE;
    if (r < 22) return $urandom_range(CORE_SIZE, (1 << NUM_W) - 1);
    if (r < 27) return $urandom_range(0, (1 << NUM_W) - 1);
    if (r < 45) return $urandom_range(1, 16);
    return $urandom_range(0, CORE_SIZE - 1);
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_error(string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTED) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic send_instr(rme_in_t ins, bit typed, rme_out_t typed_res);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      instr_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    instr_ch.valid <= 1'b1;
    instr_ch.data  <= ins;
    @(posedge clk_i);
    while (!instr_ch.ready) @(posedge clk_i);
    mod_results_q.push_back(typed ? typed_res : mod_execute(ins));
    n_sent++;
  endtask

  // result side: compare each transaction with the oldest expected result
  always @(posedge clk_i) begin
    rme_out_t got;
    rme_out_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      got = result_ch.data;
      if (mod_results_q.size() == 0) begin
        note_error($sformatf("result with nothing expected: %s", fmt_res(got)));
      end else begin
        want = mod_results_q.pop_front();
        n_checked++;
        if (want.status) n_failed_instr++;
        if (want.write_a || want.write_b) n_writes++;
        if (got.status !== want.status || got.new_a_number !== want.new_a_number ||
            got.new_b_number !== want.new_b_number || got.write_a !== want.write_a ||
            got.write_b !== want.write_b || got.target_address !== want.target_address ||
            got.source_address !== want.source_address || got.next_pc !== want.next_pc) begin
          note_error($sformatf("result %0d mismatch\n  expected %s\n  actual   %s",
                               n_checked, fmt_res(want), fmt_res(got)));
        end
      end
    end
  end

  // result side backpressure
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  initial begin
    #(20_000_000);
    $display("timeout with %0d results outstanding", mod_results_q.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    rme_in_t ins;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    instr_ch.valid = 1'b0;
    instr_ch.data  = '0;
    no_idle        = 1'b0;
    n_errors       = 0;
    n_sent         = 0;
    n_checked      = 0;
    n_failed_instr = 0;
    n_writes       = 0;

    // failures: zero divisor per modifier, core multiple as divisor, undefined code
    dir_tab.push_back('{instr(MOD_A, 0, 0, 0, 0, 0, 0, 0), 1'b1, fail_res(0, 0, 0)});
    dir_tab.push_back('{instr(MOD_B, 100, 5, 7, 3, 8000, 9, 9), 1'b1,
                        fail_res(100, 107, 105)});
    dir_tab.push_back('{instr(MOD_AB, 7999, 1, 2, 0, 4, 10, 10), 1'b1,
                        fail_res(7999, 1, 0)});
    dir_tab.push_back('{instr(MOD_BA, 0, 7999, 7999, 5, 0, 10, 10), 1'b1,
                        fail_res(0, 7999, 7999)});
    dir_tab.push_back('{instr(MOD_X, 8191, 8191, 0, 7, 0, 30, 30), 1'b1,
                        fail_res(8191, 191, 382)});
    dir_tab.push_back('{instr(MOD_F, 42, 0, 0, 0, 9, 30, 30), 1'b1, fail_res(42, 42, 42)});
    dir_tab.push_back('{instr(MOD_I, 1, 0, 0, 8000, 8000, 30, 30), 1'b1, fail_res(1, 1, 1)});
    dir_tab.push_back('{instr(MOD_UNDEF, 8191, 8191, 8191, 8191, 8191, 8191, 8191), 1'b1,
                        fail_res(8191, 382, 382)});
    dir_tab.push_back('{instr(MOD_UNDEF, 5, 3, 4, 7, 7, 20, 20), 1'b1, fail_res(5, 9, 8)});
    // passing instructions of every modifier, pc wrap and out-of-range numbers
    dir_tab.push_back('{instr(MOD_A, 0, 10, 20, 7, 0, 100, 55), 1'b0, '0});
    dir_tab.push_back('{instr(MOD_B, 7999, 1, 1, 0, 13, 3, 7999), 1'b0, '0});
    dir_tab.push_back('{instr(MOD_AB, 12, 8191, 4000, 1, 0, 6, 8191), 1'b0, '0});
    dir_tab.push_back('{instr(MOD_BA, 300, 7, 9, 0, 8191, 8191, 4), 1'b0, '0});
    dir_tab.push_back('{instr(MOD_X, 77, 2, 3, 3, 7999, 7998, 2), 1'b0, '0});
    dir_tab.push_back('{instr(MOD_F, 500, 600, 700, 8001, 8191, 8000, 5000), 1'b0, '0});
    dir_tab.push_back('{instr(MOD_I, 2, 7998, 7998, 7999, 1, 7999, 7999), 1'b0, '0});
    dir_tab.push_back('{instr(MOD_A, 8191, 0, 0, 8191, 3, 191, 8), 1'b0, '0});
    dir_tab.push_back('{instr(MOD_X, 8000, 8191, 8191, 1, 1, 8191, 8191), 1'b0, '0});
    dir_tab.push_back('{instr(MOD_F, 4000, 4000, 3999, 8191, 8191, 8190, 8190), 1'b0, '0});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_instr(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].result);

    for (int i = 0; i < N_RANDOM; i++) begin
      // every third stretch runs back to back on both sides
      if (i % 150 == 0) no_idle = ((i / 150) % 3 == 1);
      ins.command      = ($urandom_range(0, 9) == 0) ? MOD_UNDEF
                                                     : rme_mod_e'($urandom_range(0, 6));
      ins.pc           = NUM_W'(rand_num());
      ins.a_offset     = NUM_W'(rand_num());
      ins.b_offset     = NUM_W'(rand_num());
      ins.src_a_number = NUM_W'(rand_num());
      ins.src_b_number = NUM_W'(rand_num());
      ins.dst_a_number = NUM_W'(rand_num());
      ins.dst_b_number = NUM_W'(rand_num());
      send_instr(ins, 1'b0, '0);
    end
    instr_ch.valid <= 1'b0;

    while (mod_results_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);

    $display("%0d instructions sent (%0d from the directed table), %0d results checked",
             n_sent, dir_tab.size(), n_checked);
    $display("%0d failing instructions, %0d with target writes, %0d errors",
             n_failed_instr, n_writes, n_errors);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
rtl/core/rme_pkg.sv
rtl/core/rme_stream_if.sv
rtl/core/rme_decode.sv
rtl/core/rme_div_lane.sv
rtl/core/redcode_mod_execute_unit.sv
sim/tb_redcode_mod_execute_unit.sv
